### hw/rtl/tempo_map_converter_macros.svh
// Assertion macros for the tempo map converter.
// The asserting module must have signals named clk and rst in scope.
`ifndef TEMPO_MAP_CONVERTER_MACROS_SVH
`define TEMPO_MAP_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
`define TMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TMC_ASSERT(lbl, prop, msg)
`define TMC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hw/rtl/tmc_pkg.sv
package tmc_pkg;

  localparam int MAX_POINTS = 16;
  localparam int DEPTH      = MAX_POINTS + 1;
  localparam int ADDR_W     = $clog2(MAX_POINTS + 1);
  localparam int CNT_W      = ADDR_W;

  localparam logic [9:0] BASIS_RESET = 10'd60;
  // register index, taken from paddr[2]
  localparam logic CFG_BASIS = 1'b0;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_FWD    = 2'd2,
    OP_REV    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_FULL = 2'd2,
    ST_DEC  = 2'd3
  } status_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] point_time;
    logic [19:0] point_tempo;
    logic [31:0] value_in;
  } req_t;

  typedef struct packed {
    logic [31:0] value_out;
    status_t     status;
    logic        map_active;
  } rsp_t;

  typedef enum logic [1:0] {
    AR_MUL  = 2'd0,
    AR_DIV  = 2'd1,
    AR_SQRT = 2'd2
  } arith_kind_t;

  typedef struct packed {
    logic        start;
    arith_kind_t kind;
  } arith_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_sts_t;

endpackage

### hw/rtl/tmc_arith.sv
// Bit-serial arithmetic unit: shift-add multiply (64x64), restoring divide
// (64-bit dividend, 33-bit divisor, preloaded remainder) and integer square
// root (two bits of radicand per step).
module tmc_arith (
  input  logic                clk,
  input  logic                rst,
  input  tmc_pkg::arith_cmd_t cmd,
  input  logic [63:0]         opa,
  input  logic [63:0]         opb,
  input  logic [32:0]         dvs,
  output tmc_pkg::arith_sts_t sts,
  output logic [63:0]         res_hi,
  output logic [63:0]         res_lo
);

  localparam logic [6:0] MUL_STEPS  = 7'd64;
  localparam logic [6:0] DIV_STEPS  = 7'd64;
  localparam logic [6:0] SQRT_STEPS = 7'd32;

  logic [63:0] hi;
  logic [63:0] lo;
  logic [63:0] aux;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  tmc_pkg::arith_kind_t kind;

  logic [64:0] msum;
  logic [33:0] r2;
  logic [33:0] rdiff;
  logic        dge;
  logic [63:0] st;
  logic        sge;

  always_comb begin
    msum  = {1'b0, hi} + (lo[0] ? {1'b0, aux} : 65'd0);
    r2    = {hi[32:0], lo[63]};
    rdiff = r2 - {1'b0, aux[32:0]};
    dge   = r2 >= {1'b0, aux[32:0]};
    st    = lo + aux;
    sge   = hi >= st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 7'd1);
      if (cmd.start) begin
        busy <= 1'b1;
        kind <= cmd.kind;
        unique case (cmd.kind)
          tmc_pkg::AR_MUL: begin
            hi  <= '0;
            lo  <= opb;
            aux <= opa;
            cnt <= MUL_STEPS;
          end
          tmc_pkg::AR_DIV: begin
            hi  <= {31'b0, opa[32:0]};
            lo  <= opb;
            aux <= {31'b0, dvs};
            cnt <= DIV_STEPS;
          end
          default: begin
            hi  <= opb;
            lo  <= '0;
            aux <= 64'h4000_0000_0000_0000;
            cnt <= SQRT_STEPS;
          end
        endcase
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
        end
        unique case (kind)
          tmc_pkg::AR_MUL: begin
            hi <= msum[64:1];
            lo <= {msum[0], lo[63:1]};
          end
          tmc_pkg::AR_DIV: begin
            hi <= dge ? {30'b0, rdiff} : {30'b0, r2};
            lo <= {lo[62:0], dge};
          end
          default: begin
            if (sge) begin
              hi <= hi - st;
              lo <= (lo >> 1) + aux;
            end else begin
              lo <= lo >> 1;
            end
            aux <= aux >> 2;
          end
        endcase
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign res_hi   = hi;
  assign res_lo   = lo;

endmodule

### hw/rtl/tempo_map_converter.sv
// Tempo map converter. Holds up to MAX_POINTS tempo breakpoints and maps
// Q16.16 score values forward and back through a piecewise-linear tempo
// ramp; one response per request. Requests are taken one at a time and all
// heavy math runs on one bit-serial unit: multiply and divide run 64 steps,
// square root 32. An append runs a tempo divide plus its segment math. A
// conversion first scans the map one breakpoint at a time, then works out a
// constant-tempo segment, a forward ramp or a reverse ramp. The map needs no
// clearing pass after reset.
module tempo_map_converter (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  tmc_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output tmc_pkg::rsp_t  rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

`include "tempo_map_converter_macros.svh"

  localparam int AW = tmc_pkg::ADDR_W;
  localparam int CW = tmc_pkg::CNT_W;

  typedef enum logic [23:0] {
    S_IDLE  = 24'h000001,
    S_ADIV  = 24'h000002,
    S_ARD   = 24'h000004,
    S_ACHK  = 24'h000008,
    S_SRD   = 24'h000010,
    S_SCMP  = 24'h000020,
    S_GRD0  = 24'h000040,
    S_GCAP0 = 24'h000080,
    S_GCAP1 = 24'h000100,
    S_LDIV  = 24'h000200,
    S_RLIN  = 24'h000400,
    S_RBB   = 24'h000800,
    S_SQ0   = 24'h001000,
    S_SQ1   = 24'h002000,
    S_MDM   = 24'h004000,
    S_MDD   = 24'h008000,
    S_FX    = 24'h010000,
    S_SQRT  = 24'h020000,
    S_FDIV  = 24'h040000,
    S_RTERM = 24'h080000,
    S_ADD   = 24'h100000,
    S_AWR   = 24'h200000,
    S_AWR0  = 24'h400000,
    S_FIN   = 24'h800000
  } state_t;

  state_t state;

  logic [9:0] basis;

  logic [31:0] mem_time  [tmc_pkg::DEPTH];
  logic [31:0] mem_tempo [tmc_pkg::DEPTH];
  logic [31:0] mem_accel [tmc_pkg::DEPTH];
  logic [31:0] mem_conv  [tmc_pkg::DEPTH];
  logic [31:0] rd_time, rd_tempo, rd_accel, rd_conv;
  logic [AW-1:0] raddr;

  tmc_pkg::op_t    op_r;
  tmc_pkg::status_t status;
  logic [31:0] ptime_r, val_r;
  logic [19:0] ptempo_r;
  logic [CW-1:0] point_count;
  logic [CW-1:0] m;
  logic [AW-1:0] k;
  logic        issued;

  logic [31:0] q_r, t0, t1, len, d, base, base_time, base_conv, accel_w, tc;
  logic [31:0] res, conv_new;
  logic        acc_nz, lin;
  logic [63:0] sq0, sq1, bb, lin_v, p_hi, p_lo, md, x, off;

  tmc_pkg::arith_cmd_t ar_cmd;
  tmc_pkg::arith_sts_t ar_sts;
  logic [63:0] ar_opa, ar_opb, ar_hi, ar_lo;
  logic [32:0] ar_dvs;

  logic        rev, inc, md_sat, m_lt_n;
  logic [31:0] t0e, prev_time, prev_tempo, prev_conv, alen, glen, sat_sum;
  logic [64:0] sum;
  logic [63:0] term;
  logic [9:0]  basis_e;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == tmc_pkg::CFG_BASIS) ? {22'b0, basis} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      basis <= tmc_pkg::BASIS_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == tmc_pkg::CFG_BASIS)) begin
      basis <= pwdata[9:0];
    end
  end

  always_comb begin
    rev        = (op_r == tmc_pkg::OP_REV);
    t0e        = (t0 == 32'd0 && !rev) ? 32'd1 : t0;
    inc        = sq1 >= sq0;
    md_sat     = p_hi >= {32'b0, len};
    m_lt_n     = m < point_count;
    basis_e    = (basis == 10'd0) ? 10'd1 : basis;
    prev_time  = (point_count == '0) ? 32'd0 : rd_time;
    prev_tempo = (point_count == '0) ? q_r : rd_tempo;
    prev_conv  = (point_count == '0) ? 32'd0 : rd_conv;
    alen       = ptime_r - prev_time;
    glen       = m_lt_n ? rd_time - base_time : 32'd0;
    sum        = {33'b0, base} + {1'b0, off};
    sat_sum    = (sum[64:32] != '0) ? 32'hFFFF_FFFF : sum[31:0];
    term       = {18'b0, md[63:18]};
  end

  always_comb begin
    unique case (state)
      S_ARD:   raddr = point_count;
      S_SRD:   raddr = k;
      S_GRD0:  raddr = m;
      S_GCAP0: raddr = m_lt_n ? AW'(m + 1'b1) : m;
      default: raddr = '0;
    endcase
  end

  // arithmetic operand selection
  always_comb begin
    ar_cmd.start = 1'b0;
    ar_cmd.kind  = tmc_pkg::AR_MUL;
    ar_opa       = '0;
    ar_opb       = '0;
    ar_dvs       = '0;
    unique case (state)
      S_ADIV: begin
        ar_cmd.start = !issued;
        ar_cmd.kind  = tmc_pkg::AR_DIV;
        ar_opb       = {36'b0, ptempo_r, 8'b0};
        ar_dvs       = {23'b0, basis_e};
      end
      S_LDIV: begin
        ar_cmd.start = !issued;
        ar_cmd.kind  = tmc_pkg::AR_DIV;
        ar_opb       = {16'b0, d, 16'b0};
        ar_dvs       = {1'b0, t0e};
      end
      S_RLIN: begin
        ar_cmd.start = !issued;
        ar_opa       = {32'b0, d};
        ar_opb       = {32'b0, t0};
      end
      S_RBB: begin
        ar_cmd.start = !issued;
        ar_opa       = {32'b0, d};
        ar_opb       = {32'b0, d};
      end
      S_SQ0: begin
        ar_cmd.start = !issued;
        ar_opa       = {32'b0, t0e};
        ar_opb       = {32'b0, t0e};
      end
      S_SQ1: begin
        ar_cmd.start = !issued;
        ar_opa       = {32'b0, t1};
        ar_opb       = {32'b0, t1};
      end
      S_MDM: begin
        ar_cmd.start = !issued;
        ar_opa       = inc ? sq1 - sq0 : sq0 - sq1;
        ar_opb       = rev ? bb : {32'b0, d};
      end
      S_MDD: begin
        ar_cmd.start = !issued && !md_sat;
        ar_cmd.kind  = tmc_pkg::AR_DIV;
        ar_opa       = p_hi;
        ar_opb       = p_lo;
        ar_dvs       = {1'b0, len};
      end
      S_SQRT: begin
        ar_cmd.start = !issued;
        ar_cmd.kind  = tmc_pkg::AR_SQRT;
        ar_opb       = x;
      end
      S_FDIV: begin
        ar_cmd.start = !issued;
        ar_cmd.kind  = tmc_pkg::AR_DIV;
        ar_opb       = {15'b0, d, 17'b0};
        ar_dvs       = {1'b0, t0e} + {1'b0, tc};
      end
      default: begin
      end
    endcase
  end

  tmc_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .cmd    (ar_cmd),
    .opa    (ar_opa),
    .opb    (ar_opb),
    .dvs    (ar_dvs),
    .sts    (ar_sts),
    .res_hi (ar_hi),
    .res_lo (ar_lo)
  );

  // breakpoint memories
  always_ff @(posedge clk) begin
    if (state == S_AWR) begin
      mem_time[AW'(point_count + 1'b1)]  <= ptime_r;
      mem_tempo[AW'(point_count + 1'b1)] <= q_r;
      mem_accel[point_count]             <= accel_w;
      mem_conv[AW'(point_count + 1'b1)]  <= conv_new;
    end else if (state == S_AWR0) begin
      mem_time[0]  <= 32'd0;
      mem_tempo[0] <= q_r;
      mem_conv[0]  <= 32'd0;
    end
    rd_time  <= mem_time[raddr];
    rd_tempo <= mem_tempo[raddr];
    rd_accel <= mem_accel[raddr];
    rd_conv  <= mem_conv[raddr];
  end

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= '0;
      issued      <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (ar_sts.done) begin
        issued <= 1'b0;
      end else if (ar_cmd.start) begin
        issued <= 1'b1;
      end
      if (rsp_valid && !rsp_stall && (state != S_FIN)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_r     <= req.operation;
            ptime_r  <= req.point_time;
            ptempo_r <= req.point_tempo;
            val_r    <= req.value_in;
            status   <= tmc_pkg::ST_OK;
            res      <= 32'd0;
            m        <= '0;
            k        <= AW'(1);
            unique case (req.operation)
              tmc_pkg::OP_CLEAR: begin
                point_count <= '0;
                state       <= S_FIN;
              end
              tmc_pkg::OP_APPEND: state <= S_ADIV;
              default: begin
                if (point_count == '0) begin
                  res   <= req.value_in;
                  state <= S_FIN;
                end else begin
                  state <= S_SRD;
                end
              end
            endcase
          end
        end
        S_ADIV: begin
          if (ar_sts.done) begin
            q_r   <= ar_lo[31:0];
            state <= S_ARD;
          end
        end
        S_ARD: state <= S_ACHK;
        S_ACHK: begin
          if (point_count >= CW'(tmc_pkg::MAX_POINTS)) begin
            status <= tmc_pkg::ST_FULL;
            state  <= S_FIN;
          end else if (q_r == 32'd0) begin
            status <= tmc_pkg::ST_ZERO;
            state  <= S_FIN;
          end else if (ptime_r < prev_time) begin
            status <= tmc_pkg::ST_DEC;
            state  <= S_FIN;
          end else begin
            t0      <= prev_tempo;
            t1      <= q_r;
            len     <= alen;
            d       <= alen;
            base    <= prev_conv;
            accel_w <= (alen == 32'd0) ? 32'd0 : q_r - prev_tempo;
            lin     <= (alen == 32'd0) || (q_r == prev_tempo);
            state   <= ((alen == 32'd0) || (q_r == prev_tempo)) ? S_LDIV : S_SQ0;
          end
        end
        S_SRD: state <= S_SCMP;
        S_SCMP: begin
          if ((rev ? rd_conv : rd_time) < val_r) begin
            m <= m + 1'b1;
          end
          if (k == point_count) begin
            state <= S_GRD0;
          end else begin
            k     <= k + 1'b1;
            state <= S_SRD;
          end
        end
        S_GRD0: state <= S_GCAP0;
        S_GCAP0: begin
          t0        <= rd_tempo;
          t1        <= rd_tempo;
          base_time <= rd_time;
          base_conv <= rd_conv;
          acc_nz    <= (rd_accel != 32'd0);
          state     <= S_GCAP1;
        end
        S_GCAP1: begin
          if (m_lt_n) begin
            t1 <= rd_tempo;
          end
          len  <= glen;
          lin  <= !(m_lt_n && acc_nz && (glen != 32'd0));
          d    <= rev ? val_r - base_conv : val_r - base_time;
          base <= rev ? base_time : base_conv;
          if (rev) begin
            state <= S_RLIN;
          end else begin
            state <= (m_lt_n && acc_nz && (glen != 32'd0)) ? S_SQ0 : S_LDIV;
          end
        end
        S_LDIV: begin
          if (ar_sts.done) begin
            off   <= ar_lo;
            state <= S_ADD;
          end
        end
        S_RLIN: begin
          if (ar_sts.done) begin
            lin_v <= {16'b0, ar_lo[63:16]};
            off   <= {16'b0, ar_lo[63:16]};
            state <= lin ? S_ADD : S_RBB;
          end
        end
        S_RBB: begin
          if (ar_sts.done) begin
            bb    <= {16'b0, ar_lo[63:16]};
            state <= S_SQ0;
          end
        end
        S_SQ0: begin
          if (ar_sts.done) begin
            sq0   <= ar_lo;
            state <= S_SQ1;
          end
        end
        S_SQ1: begin
          if (ar_sts.done) begin
            sq1   <= ar_lo;
            state <= S_MDM;
          end
        end
        S_MDM: begin
          if (ar_sts.done) begin
            p_hi  <= ar_hi;
            p_lo  <= ar_lo;
            state <= S_MDD;
          end
        end
        S_MDD: begin
          // quotient would not fit: saturate without dividing
          if (!issued && md_sat) begin
            md    <= 64'hFFFF_FFFF_FFFF_FFFF;
            state <= rev ? S_RTERM : S_FX;
          end else if (ar_sts.done) begin
            md    <= ar_lo;
            state <= rev ? S_RTERM : S_FX;
          end
        end
        S_FX: begin
          if (inc) begin
            x <= sq0 + md;
          end else begin
            x <= (md > sq0) ? 64'd0 : sq0 - md;
          end
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (ar_sts.done) begin
            tc    <= ar_lo[31:0];
            state <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (ar_sts.done) begin
            off   <= ar_lo;
            state <= S_ADD;
          end
        end
        S_RTERM: begin
          if (inc) begin
            off <= lin_v + term;
          end else begin
            off <= (lin_v >= term) ? lin_v - term : 64'd0;
          end
          state <= S_ADD;
        end
        S_ADD: begin
          if (op_r == tmc_pkg::OP_APPEND) begin
            conv_new <= sat_sum;
            state    <= S_AWR;
          end else begin
            res   <= sat_sum;
            state <= S_FIN;
          end
        end
        S_AWR: begin
          if (point_count == '0) begin
            state <= S_AWR0;
          end else begin
            point_count <= point_count + 1'b1;
            state       <= S_FIN;
          end
        end
        S_AWR0: begin
          point_count <= point_count + 1'b1;
          state       <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!rsp_valid || !rsp_stall) begin
            rsp.value_out  <= res;
            rsp.status     <= status;
            rsp.map_active <= (point_count != '0);
            rsp_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TMC_ASSERT(a_count_range, point_count <= CW'(tmc_pkg::MAX_POINTS), "point count over max")
  `TMC_ASSERT(a_start_free, ar_cmd.start |-> !ar_sts.busy, "arith started while busy")
  `TMC_ASSERT(a_done_issued, ar_sts.done |-> issued, "arith done without request")
  `TMC_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, state != S_IDLE, "accept left idle")

endmodule
